### hw/rtl/amf_pkg.sv
// shared types and operation codes for the a32 alu with nzcv flags
`default_nettype none

package amf_pkg;

  // operation codes, plain form then flag-setting form where one exists (MLS and UMAAL have none)
  localparam logic [4:0] KIND_AND    = 5'd0;
  localparam logic [4:0] KIND_ANDS   = 5'd1;
  localparam logic [4:0] KIND_EOR    = 5'd2;
  localparam logic [4:0] KIND_EORS   = 5'd3;
  localparam logic [4:0] KIND_RSB    = 5'd4;
  localparam logic [4:0] KIND_RSBS   = 5'd5;
  localparam logic [4:0] KIND_SUB    = 5'd6;
  localparam logic [4:0] KIND_SUBS   = 5'd7;
  localparam logic [4:0] KIND_ADD    = 5'd8;
  localparam logic [4:0] KIND_ADDS   = 5'd9;
  localparam logic [4:0] KIND_ADC    = 5'd10;
  localparam logic [4:0] KIND_ADCS   = 5'd11;
  localparam logic [4:0] KIND_SBC    = 5'd12;
  localparam logic [4:0] KIND_SBCS   = 5'd13;
  localparam logic [4:0] KIND_RSC    = 5'd14;
  localparam logic [4:0] KIND_RSCS   = 5'd15;
  localparam logic [4:0] KIND_MLA    = 5'd16;
  localparam logic [4:0] KIND_MLAS   = 5'd17;
  localparam logic [4:0] KIND_MLS    = 5'd18;
  localparam logic [4:0] KIND_UMAAL  = 5'd19;
  localparam logic [4:0] KIND_UMLAL  = 5'd20;
  localparam logic [4:0] KIND_UMLALS = 5'd21;
  localparam logic [4:0] KIND_SMLAL  = 5'd22;
  localparam logic [4:0] KIND_SMLALS = 5'd23;

  // input word
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] first_operand;
    logic [31:0] second_operand;
    logic [31:0] second_operand_rrx;
    logic [31:0] third_operand;
    logic [31:0] fourth_operand;
    logic        shifter_carry;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
  } out_word_t;

  // nzcv flag group
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // operands after the multiply stage
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] a;
    logic [31:0] op2;
    logic [31:0] m3;
    logic        sc;
    logic [63:0] acc;
    logic [63:0] prod;
  } ex_t;

endpackage

`default_nettype wire

### hw/rtl/amf_in_if.sv
// input channel carrying one operation word
`default_nettype none

interface amf_in_if;
  logic              valid;
  logic              ready;
  amf_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/amf_out_if.sv
// output channel carrying one result word
`default_nettype none

interface amf_out_if;
  logic               valid;
  logic               ready;
  amf_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/amf_alu.sv
// final add stage: data ops, multiply accumulate and nzcv update
`default_nettype none

module amf_alu (
  input  amf_pkg::ex_t    ex,
  input  amf_pkg::flags_t flags,
  output logic [31:0]     result_low,
  output logic [31:0]     result_high,
  output amf_pkg::flags_t flags_next
);

  logic [31:0] add_x;
  logic [31:0] add_y;
  logic        add_cin;
  logic [32:0] add_sum;
  logic [63:0] mac_sum;
  logic [31:0] mls_diff;
  logic        add_ovf;

  // operand selection for the 32-bit adder
  always_comb begin
    add_x   = ex.a;
    add_y   = ex.op2;
    add_cin = 1'b0;
    case (ex.kind)
      amf_pkg::KIND_RSB, amf_pkg::KIND_RSBS: begin
        add_x   = ~ex.a;
        add_cin = 1'b1;
      end
      amf_pkg::KIND_SUB, amf_pkg::KIND_SUBS: begin
        add_y   = ~ex.op2;
        add_cin = 1'b1;
      end
      amf_pkg::KIND_ADC, amf_pkg::KIND_ADCS: begin
        add_cin = flags.c;
      end
      amf_pkg::KIND_SBC, amf_pkg::KIND_SBCS: begin
        add_y   = ~ex.op2;
        add_cin = flags.c;
      end
      amf_pkg::KIND_RSC, amf_pkg::KIND_RSCS: begin
        add_x   = ~ex.a;
        add_cin = flags.c;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum  = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
  assign add_ovf  = ((add_x[31] ^ add_sum[31]) & (add_y[31] ^ add_sum[31]));
  assign mac_sum  = ex.prod + ex.acc;
  assign mls_diff = ex.m3 - ex.prod[31:0];

  // result and flag selection
  always_comb begin
    result_low  = '0;
    result_high = '0;
    flags_next  = flags;
    case (ex.kind)
      amf_pkg::KIND_AND: result_low = ex.a & ex.op2;
      amf_pkg::KIND_EOR: result_low = ex.a ^ ex.op2;
      amf_pkg::KIND_ANDS, amf_pkg::KIND_EORS: begin
        result_low   = (ex.kind == amf_pkg::KIND_ANDS) ? (ex.a & ex.op2) : (ex.a ^ ex.op2);
        flags_next.n = result_low[31];
        flags_next.z = (result_low == 32'd0);
        flags_next.c = ex.sc;
      end
      amf_pkg::KIND_RSB, amf_pkg::KIND_SUB, amf_pkg::KIND_ADD,
      amf_pkg::KIND_ADC, amf_pkg::KIND_SBC, amf_pkg::KIND_RSC: begin
        result_low = add_sum[31:0];
      end
      amf_pkg::KIND_RSBS, amf_pkg::KIND_SUBS, amf_pkg::KIND_ADDS,
      amf_pkg::KIND_ADCS, amf_pkg::KIND_SBCS, amf_pkg::KIND_RSCS: begin
        result_low   = add_sum[31:0];
        flags_next.n = add_sum[31];
        flags_next.z = (add_sum[31:0] == 32'd0);
        flags_next.c = add_sum[32];
        flags_next.v = add_ovf;
      end
      amf_pkg::KIND_MLA: result_low = mac_sum[31:0];
      amf_pkg::KIND_MLAS: begin
        result_low   = mac_sum[31:0];
        flags_next.n = mac_sum[31];
        flags_next.z = (mac_sum[31:0] == 32'd0);
      end
      amf_pkg::KIND_MLS: result_low = mls_diff;
      amf_pkg::KIND_UMAAL, amf_pkg::KIND_UMLAL, amf_pkg::KIND_SMLAL: begin
        result_low  = mac_sum[31:0];
        result_high = mac_sum[63:32];
      end
      amf_pkg::KIND_UMLALS, amf_pkg::KIND_SMLALS: begin
        result_low   = mac_sum[31:0];
        result_high  = mac_sum[63:32];
        flags_next.n = mac_sum[63];
        flags_next.z = (mac_sum == 64'd0);
      end
      default: begin
        result_low = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/arm_alu_multiply_flags_core.sv
// top level: three-stage a32 alu with multiply and nzcv flag register
//
// Channel op (sink) takes one operation word: kind, operands and shifter carry.
// Channel res (source) gives one result word per operation: low and high result
// words and the nzcv flags after that operation. A word moves when valid and
// ready are both high at a rising clock edge.
// Stages: input register, multiply stage (one 33x33 signed multiplier shared by
// all multiply forms, product registered), then the add/flag stage feeding the
// output register. An accepted word passes the input, multiply-stage and output
// registers in that order; throughput is one word per cycle while res is not stalled.
// The flag register is read and written in the add/flag stage only, so carry
// dependent operations see the flags of the word just before them with no gap.
// Reset (rst, synchronous) empties all stages and clears nzcv to zero.
// When res is stalled the stages fill up; op.ready falls only once every stage
// holds a word, and nothing is dropped or repeated.
`default_nettype none

module arm_alu_multiply_flags_core (
  input  logic      clk,
  input  logic      rst,
  amf_in_if.sink    op,
  amf_out_if.source res
);

  amf_pkg::in_word_t s1;
  logic              s1_valid;
  amf_pkg::ex_t      s2;
  amf_pkg::ex_t      s2_next;
  logic              s2_valid;
  amf_pkg::flags_t   flags;
  amf_pkg::flags_t   flags_next;
  logic [31:0]       alu_low;
  logic [31:0]       alu_high;
  logic              adv_out;
  logic              adv_s2;
  logic              adv_s1;
  logic              short_mul;
  logic              signed_mul;
  logic signed [32:0] mul_x;
  logic signed [32:0] mul_y;
  logic signed [65:0] mul_p;
  logic [32:0]        umaal_add;

  // pipeline flow control
  assign adv_out  = !res.valid || res.ready;
  assign adv_s2   = !s2_valid || adv_out;
  assign adv_s1   = !s1_valid || adv_s2;
  assign op.ready = adv_s1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_s1) begin
      s1_valid <= op.valid;
    end
    if (adv_s1 && op.valid) begin
      s1 <= op.data;
    end
  end

  // multiply stage: operand pick and accumulator forming
  assign short_mul  = (s1.kind == amf_pkg::KIND_MLA) || (s1.kind == amf_pkg::KIND_MLAS) ||
                      (s1.kind == amf_pkg::KIND_MLS);
  assign signed_mul = (s1.kind == amf_pkg::KIND_SMLAL) || (s1.kind == amf_pkg::KIND_SMLALS);
  assign umaal_add  = {1'b0, s1.first_operand} + {1'b0, s1.fourth_operand};

  always_comb begin
    if (short_mul) begin
      mul_x = $signed({1'b0, s1.first_operand});
      mul_y = $signed({1'b0, s1.second_operand});
    end else begin
      mul_x = $signed({signed_mul & s1.second_operand[31], s1.second_operand});
      mul_y = $signed({signed_mul & s1.third_operand[31], s1.third_operand});
    end
  end

  assign mul_p = mul_x * mul_y;

  always_comb begin
    s2_next.kind = s1.kind;
    s2_next.a    = s1.first_operand;
    s2_next.op2  = s1.second_operand | s1.second_operand_rrx;
    s2_next.m3   = s1.third_operand;
    s2_next.sc   = s1.shifter_carry;
    s2_next.prod = mul_p[63:0];
    if (short_mul) begin
      s2_next.acc = {32'd0, s1.third_operand};
    end else if (s1.kind == amf_pkg::KIND_UMAAL) begin
      s2_next.acc = {31'd0, umaal_add};
    end else begin
      s2_next.acc = {s1.first_operand, s1.fourth_operand};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv_s2) begin
      s2_valid <= s1_valid;
    end
    if (adv_s2 && s1_valid) begin
      s2 <= s2_next;
    end
  end

  // add and flag stage
  amf_alu u_alu (
    .ex          (s2),
    .flags       (flags),
    .result_low  (alu_low),
    .result_high (alu_high),
    .flags_next  (flags_next)
  );

  // flag register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (adv_out) begin
        res.valid <= s2_valid;
      end
      if (adv_out && s2_valid) begin
        flags <= flags_next;
      end
    end
    if (adv_out && s2_valid) begin
      res.data.result_low  <= alu_low;
      res.data.result_high <= alu_high;
      res.data.flag_n      <= flags_next.n;
      res.data.flag_z      <= flags_next.z;
      res.data.flag_c      <= flags_next.c;
      res.data.flag_v      <= flags_next.v;
    end
  end

  // input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !op.ready |-> (s1_valid && s2_valid && res.valid && !res.ready))
    else $error("input stalled with a free stage");

  // flags change only when a word leaves the add stage
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !(adv_out && s2_valid) |=> $stable(flags))
    else $error("flags changed without a word");

  // shown flags match the flag register
  a_flags_shown: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.flag_n == flags.n && res.data.flag_z == flags.z &&
                   res.data.flag_c == flags.c && res.data.flag_v == flags.v))
    else $error("output flags differ from flag register");

  // 32-bit operations give a zero high word
  a_high_zero: assert property (@(posedge clk) disable iff (rst)
    (adv_out && s2_valid && s2.kind < amf_pkg::KIND_UMAAL) |=> (res.data.result_high == 32'd0))
    else $error("nonzero high word on a 32-bit operation");

endmodule

`default_nettype wire
